FILE: rtl/hmc_pkg.sv
// Shared types, codes and helpers for the headlamp mode controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package hmc_pkg;

    // Lamp mode codes.
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_TOP   = 2'd1;
    localparam logic [1:0] MODE_FRONT = 2'd2;
    localparam logic [1:0] MODE_WRAP  = 2'd3;

    // Register indexes on the configuration port (word address bits).
    localparam logic [2:0] REG_DEBOUNCE_LIMIT = 3'd0;
    localparam logic [2:0] REG_PRESCALE_LIMIT = 3'd1;
    localparam logic [2:0] REG_OFF_ARM_UNITS  = 3'd2;
    localparam logic [2:0] REG_IDLE_UNIT_MS   = 3'd3;
    localparam logic [2:0] REG_IDLE_UNITS     = 3'd4;

    // Register reset values.
    localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd25;
    localparam logic [7:0] PRESCALE_LIMIT_RST = 8'd25;
    localparam logic [7:0] OFF_ARM_UNITS_RST  = 8'd200;
    localparam logic [7:0] IDLE_UNIT_MS_RST   = 8'd250;
    localparam logic [7:0] IDLE_UNITS_RST     = 8'd20;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Configuration register set handed to the step logic.
    typedef struct packed {
        logic [7:0] debounce_limit;
        logic [7:0] prescale_limit;
        logic [7:0] off_arm_units;
        logic [7:0] idle_unit_ms;
        logic [7:0] idle_units;
    } hmc_cfg_t;

    // One result item.
    typedef struct packed {
        logic       led_top;
        logic       front_led;
        logic       save_strobe;
        logic [1:0] saved_mode;
        logic       sleep_request;
    } hmc_result_t;

    // Saturating increment of an 8-bit counter.
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == COUNT_MAX) ? v : v + 8'd1;
    endfunction

endpackage

FILE: rtl/hmc_step.sv
// Per-tick state and next-state logic of the headlamp mode controller.
// Depends on hmc_pkg; instantiated by headlamp_mode_controller.
`timescale 1ns / 1ps

module hmc_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic                key_level,
    input  hmc_pkg::hmc_cfg_t   cfg,
    output hmc_pkg::hmc_result_t result
);
    import hmc_pkg::*;

    logic [7:0] prescale_count_reg, prescale_count_next;
    logic [7:0] long_units_reg, long_units_next;
    logic       stable_key_reg, stable_key_next;
    logic [7:0] debounce_count_reg, debounce_count_next;
    logic       key_held_reg, key_held_next;
    logic       press_pending_reg, press_pending_next;
    logic       off_armed_reg, off_armed_next;
    logic [1:0] lamp_mode_reg, lamp_mode_next;
    logic [1:0] remembered_mode_reg, remembered_mode_next;
    logic [7:0] idle_ms_count_reg, idle_ms_count_next;
    logic [7:0] idle_unit_count_reg, idle_unit_count_next;

    logic [7:0] prescale_inc;
    logic [7:0] long_units_tick;
    logic [7:0] idle_ms_inc;
    logic [7:0] idle_units_tick;
    logic       key_differs;
    logic       pressed;
    logic       press_edge;
    logic       pending_set;
    logic       release_done;
    logic       armed_mid;
    logic [1:0] mode_inc;
    logic       sleep;

    always_comb begin
        // Prescaler that produces long time units.
        prescale_inc = sat_inc(prescale_count_reg);
        if (prescale_inc > cfg.prescale_limit) begin
            prescale_count_next = 8'd0;
            long_units_tick     = sat_inc(long_units_reg);
        end else begin
            prescale_count_next = prescale_inc;
            long_units_tick     = long_units_reg;
        end

        // Idle timer runs only while the lamp is off.
        idle_ms_inc = sat_inc(idle_ms_count_reg);
        if (lamp_mode_reg == MODE_OFF) begin
            if (idle_ms_inc > cfg.idle_unit_ms) begin
                idle_ms_count_next = 8'd0;
                idle_units_tick    = sat_inc(idle_unit_count_reg);
            end else begin
                idle_ms_count_next = idle_ms_inc;
                idle_units_tick    = idle_unit_count_reg;
            end
        end else begin
            idle_ms_count_next = 8'd0;
            idle_units_tick    = 8'd0;
        end

        // Debounce: the stable level follows once the difference outlasts the limit.
        key_differs     = (key_level != stable_key_reg);
        stable_key_next = stable_key_reg;
        key_held_next   = key_held_reg;
        pressed         = ~stable_key_reg;
        press_edge      = 1'b0;
        if (key_differs) begin
            debounce_count_next = sat_inc(debounce_count_reg);
            if (debounce_count_next > cfg.debounce_limit) begin
                stable_key_next     = key_level;
                debounce_count_next = 8'd0;
            end
        end else begin
            debounce_count_next = 8'd0;
            press_edge          = pressed & ~key_held_reg;
            key_held_next       = pressed;
        end

        // A press followed by a release completes one key action.
        pending_set        = press_pending_reg | (key_held_next & press_edge);
        release_done       = ~key_held_next & pending_set;
        press_pending_next = pending_set & ~release_done;

        // Off-arm timer counts while lit, released and not yet armed.
        armed_mid = off_armed_reg;
        if (!key_held_next && lamp_mode_reg != MODE_OFF && !off_armed_reg) begin
            if (long_units_tick >= cfg.off_arm_units) begin
                armed_mid       = 1'b1;
                long_units_next = 8'd0;
            end else begin
                long_units_next = long_units_tick;
            end
        end else begin
            long_units_next = 8'd0;
        end

        // Mode change on a completed key action.
        mode_inc             = lamp_mode_reg + 2'd1;
        lamp_mode_next       = lamp_mode_reg;
        remembered_mode_next = remembered_mode_reg;
        off_armed_next       = armed_mid;
        if (release_done) begin
            if (!armed_mid) begin
                if (remembered_mode_reg != MODE_OFF) begin
                    lamp_mode_next = remembered_mode_reg;
                end else if (mode_inc == MODE_WRAP) begin
                    lamp_mode_next = MODE_OFF;
                end else begin
                    lamp_mode_next = mode_inc;
                end
                remembered_mode_next = MODE_OFF;
            end else begin
                remembered_mode_next = lamp_mode_reg;
                lamp_mode_next       = MODE_OFF;
                off_armed_next       = 1'b0;
            end
        end

        // Sleep request once enough idle units have gone by.
        sleep = (idle_units_tick >= cfg.idle_units);
        idle_unit_count_next = sleep ? 8'd0 : idle_units_tick;

        result.led_top       = (lamp_mode_next == MODE_TOP);
        result.front_led     = (lamp_mode_next == MODE_FRONT);
        result.save_strobe   = release_done;
        result.saved_mode    = release_done ? lamp_mode_next : MODE_OFF;
        result.sleep_request = sleep;
    end

    // State advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_count_reg  <= 8'd0;
            long_units_reg      <= 8'd0;
            stable_key_reg      <= 1'b1;
            debounce_count_reg  <= 8'd0;
            key_held_reg        <= 1'b0;
            press_pending_reg   <= 1'b0;
            off_armed_reg       <= 1'b0;
            lamp_mode_reg       <= MODE_OFF;
            remembered_mode_reg <= MODE_OFF;
            idle_ms_count_reg   <= 8'd0;
            idle_unit_count_reg <= 8'd0;
        end else if (step_en) begin
            prescale_count_reg  <= prescale_count_next;
            long_units_reg      <= long_units_next;
            stable_key_reg      <= stable_key_next;
            debounce_count_reg  <= debounce_count_next;
            key_held_reg        <= key_held_next;
            press_pending_reg   <= press_pending_next;
            off_armed_reg       <= off_armed_next;
            lamp_mode_reg       <= lamp_mode_next;
            remembered_mode_reg <= remembered_mode_next;
            idle_ms_count_reg   <= idle_ms_count_next;
            idle_unit_count_reg <= idle_unit_count_next;
        end
    end

endmodule

FILE: rtl/headlamp_mode_controller.sv
// Top level of the headlamp mode controller: stream ports, APB registers,
// result register. Depends on hmc_pkg and hmc_step.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata[0] key_level (raw, 0 = pressed)
// m_        out        m_tvalid / m_tready  m_tdata[5:0] lamp outputs and strobes
// APB       in         psel/penable/pready  five 8-bit registers at 4*i
//
// One input item (one millisecond tick) is taken per clock while s_tready is high;
// each item yields one result item in the next cycle from the result register.
// The input is ready whenever the result register is empty or being drained,
// so a stalled output only blocks the input while a result is waiting.
// aresetn is synchronous, active low; it clears all state except the result data
// register and loads the register defaults.

module headlamp_mode_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] key_level, [7:1] zero
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] led_top, [1] front_led, [2] save_strobe,
                                   // [4:3] saved_mode, [5] sleep_request, [7:6] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hmc_pkg::*;

    hmc_cfg_t    cfg_reg;
    hmc_result_t step_result;
    hmc_result_t result_reg;
    logic        m_tvalid_reg;
    logic        s_accept;
    logic        cfg_write;
    logic [2:0]  reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel & penable & pwrite & pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_limit <= DEBOUNCE_LIMIT_RST;
            cfg_reg.prescale_limit <= PRESCALE_LIMIT_RST;
            cfg_reg.off_arm_units  <= OFF_ARM_UNITS_RST;
            cfg_reg.idle_unit_ms   <= IDLE_UNIT_MS_RST;
            cfg_reg.idle_units     <= IDLE_UNITS_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit <= pwdata[7:0];
                REG_PRESCALE_LIMIT: cfg_reg.prescale_limit <= pwdata[7:0];
                REG_OFF_ARM_UNITS:  cfg_reg.off_arm_units  <= pwdata[7:0];
                REG_IDLE_UNIT_MS:   cfg_reg.idle_unit_ms   <= pwdata[7:0];
                REG_IDLE_UNITS:     cfg_reg.idle_units     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_index)
            REG_DEBOUNCE_LIMIT: prdata = {24'd0, cfg_reg.debounce_limit};
            REG_PRESCALE_LIMIT: prdata = {24'd0, cfg_reg.prescale_limit};
            REG_OFF_ARM_UNITS:  prdata = {24'd0, cfg_reg.off_arm_units};
            REG_IDLE_UNIT_MS:   prdata = {24'd0, cfg_reg.idle_unit_ms};
            REG_IDLE_UNITS:     prdata = {24'd0, cfg_reg.idle_units};
            default:            prdata = 32'd0;
        endcase
    end

    // Input is taken when the result register is free or drains this cycle.
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign s_accept = s_tvalid & s_tready;

    hmc_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (s_accept),
        .key_level (s_tdata[0]),
        .cfg       (cfg_reg),
        .result    (step_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg.sleep_request, result_reg.saved_mode,
                       result_reg.save_strobe, result_reg.front_led, result_reg.led_top};

    // An accepted item always shows up as a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted item produced no result");

    // Both LEDs are never driven together.
    a_leds_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_reg.led_top && result_reg.front_led))
        else $error("both LEDs on");

    // A saved mode is reported only with the strobe and matches the LEDs.
    a_saved_mode_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((!result_reg.save_strobe && result_reg.saved_mode == MODE_OFF) ||
                      (result_reg.save_strobe &&
                       result_reg.led_top == (result_reg.saved_mode == MODE_TOP) &&
                       result_reg.front_led == (result_reg.saved_mode == MODE_FRONT))))
        else $error("saved mode inconsistent with strobe or LEDs");

endmodule

FILE: verif/headlamp_mode_controller_test.sv
// Self-checking testbench for headlamp_mode_controller: key ticks in, lamp results out,
// each result checked against an in-bench prediction of debounce, mode and sleep logic.
// Depends on hmc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module headlamp_mode_controller_test;

    import hmc_pkg::*;

    localparam int ITEM_GAP_MAX    = 3;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int MISMATCH_SHOWN  = 10;

    // Directed key pattern, first tick leftmost: idle, press to top, wait for arming,
    // press to off, press to restore, a one-tick bounce, and one more press.
    localparam logic [0:29] DIRECTED_KEYS = 30'b1_000111_111_000111_000111_01_000111;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [0] key_level, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [0] led_top, [1] front_led, [2] save_strobe,
                             // [4:3] saved_mode, [5] sleep_request, [7:6] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted configuration and state of the controller.
    logic [7:0] cfg_debounce, cfg_prescale, cfg_off_arm, cfg_idle_ms, cfg_idle_units;
    logic [7:0] prescale_cnt, long_cnt, debounce_cnt, idle_ms_cnt, idle_unit_cnt;
    logic       stable_level, key_down, press_open, armed;
    logic [1:0] mode_now, mode_kept;

    hmc_result_t lamp_expected[$];

    bit pace_gaps  = 1'b0;
    bit drain_gaps = 1'b0;
    int hold_len   = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int saves_seen = 0;
    int sleeps_seen = 0;

    headlamp_mode_controller uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [7:0] bump8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Put the prediction into its post-reset state.
    function automatic void lamp_reset();
        cfg_debounce   = DEBOUNCE_LIMIT_RST;
        cfg_prescale   = PRESCALE_LIMIT_RST;
        cfg_off_arm    = OFF_ARM_UNITS_RST;
        cfg_idle_ms    = IDLE_UNIT_MS_RST;
        cfg_idle_units = IDLE_UNITS_RST;
        prescale_cnt   = 8'd0;
        long_cnt       = 8'd0;
        debounce_cnt   = 8'd0;
        idle_ms_cnt    = 8'd0;
        idle_unit_cnt  = 8'd0;
        stable_level   = 1'b1;
        key_down       = 1'b0;
        press_open     = 1'b0;
        armed          = 1'b0;
        mode_now       = MODE_OFF;
        mode_kept      = MODE_OFF;
    endfunction

    // Advance the prediction by one millisecond tick and return the lamp result.
    function automatic hmc_result_t lamp_tick(input logic key);
        hmc_result_t r;
        logic press_edge;
        logic released_now;
        logic pressed;
        press_edge   = 1'b0;
        released_now = 1'b0;
        r            = '0;

        // Free-running prescaler, then the debounce and idle counters.
        prescale_cnt = bump8(prescale_cnt);
        if (prescale_cnt > cfg_prescale) begin
            prescale_cnt = 8'd0;
            long_cnt     = bump8(long_cnt);
        end
        debounce_cnt = (key != stable_level) ? bump8(debounce_cnt) : 8'd0;
        if (mode_now == MODE_OFF) begin
            idle_ms_cnt = bump8(idle_ms_cnt);
            if (idle_ms_cnt > cfg_idle_ms) begin
                idle_ms_cnt   = 8'd0;
                idle_unit_cnt = bump8(idle_unit_cnt);
            end
        end else begin
            idle_ms_cnt   = 8'd0;
            idle_unit_cnt = 8'd0;
        end

        // The stable level follows the key only after the debounce time.
        if (key != stable_level) begin
            if (debounce_cnt > cfg_debounce) begin
                stable_level = key;
                debounce_cnt = 8'd0;
            end
        end else begin
            pressed    = ~stable_level;
            press_edge = pressed & ~key_down;
            key_down   = pressed;
        end
        if (key_down && press_edge)
            press_open = 1'b1;
        if (!key_down && press_open) begin
            released_now = 1'b1;
            press_open   = 1'b0;
        end

        // Arm the lamp after it stays lit with the key released long enough.
        if (!key_down && mode_now != MODE_OFF && !armed) begin
            if (long_cnt >= cfg_off_arm) begin
                armed    = 1'b1;
                long_cnt = 8'd0;
            end
        end else begin
            long_cnt = 8'd0;
        end

        // A completed press either steps or restores the mode, or turns an armed lamp off.
        if (released_now) begin
            if (!armed) begin
                mode_now  = (mode_kept != MODE_OFF) ? mode_kept : mode_now + 2'd1;
                if (mode_now == MODE_WRAP)
                    mode_now = MODE_OFF;
                mode_kept = MODE_OFF;
            end else begin
                mode_kept = mode_now;
                mode_now  = MODE_OFF;
                armed     = 1'b0;
            end
            r.save_strobe = 1'b1;
            r.saved_mode  = mode_now;
            saves_seen++;
        end

        if (idle_unit_cnt >= cfg_idle_units) begin
            r.sleep_request = 1'b1;
            idle_unit_cnt   = 8'd0;
            sleeps_seen++;
        end

        r.led_top   = (mode_now == MODE_TOP);
        r.front_led = (mode_now == MODE_FRONT);
        return r;
    endfunction

    // Offer one key tick, wait for it to be taken and record its prediction.
    task automatic send_tick(input logic key);
        int gap;
        gap = pace_gaps ? $urandom_range(0, ITEM_GAP_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, key};
        do @(posedge aclk); while (!s_tready);
        lamp_expected.push_back(lamp_tick(key));
        items_sent++;
    endtask

    // Stop offering items and wait until every predicted result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (lamp_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register through the APB port, setup then access.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE_LIMIT: cfg_debounce   = value;
            REG_PRESCALE_LIMIT: cfg_prescale   = value;
            REG_OFF_ARM_UNITS:  cfg_off_arm    = value;
            REG_IDLE_UNIT_MS:   cfg_idle_ms    = value;
            REG_IDLE_UNITS:     cfg_idle_units = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] deb, input logic [7:0] pre,
                              input logic [7:0] arm, input logic [7:0] ims,
                              input logic [7:0] iun);
        write_reg(REG_DEBOUNCE_LIMIT, deb);
        write_reg(REG_PRESCALE_LIMIT, pre);
        write_reg(REG_OFF_ARM_UNITS, arm);
        write_reg(REG_IDLE_UNIT_MS, ims);
        write_reg(REG_IDLE_UNITS, iun);
    endtask

    // A run of one key level with an occasional one-tick flip as contact noise.
    task automatic key_run(input logic level, input int len);
        repeat (len) send_tick(($urandom_range(0, 15) == 0) ? ~level : level);
    endtask

    // A few random ticks under the reset configuration.
    task automatic test_reset_config();
        pace_gaps  = 1'b1;
        drain_gaps = 1'b1;
        repeat (12) send_tick(1'($urandom_range(0, 1)));
        settle();
    endtask

    // All limits at 1: stepping, arming, off, restore and a bounce.
    task automatic test_directed_modes();
        set_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        for (int i = 0; i < 30; i++)
            send_tick(DIRECTED_KEYS[i]);
        settle();
    endtask

    // Limits at 255, idle units at 1: the saturated counters never trigger a key change or a sleep.
    task automatic test_saturated_limits();
        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1);
        pace_gaps = 1'b0;
        repeat (262) send_tick(1'b0);
        settle();
    endtask

    // Press-and-release runs of random length; small random limits, last idle limit 255.
    task automatic test_press_sequences(input int phases, input int items_per_phase);
        int start;
        for (int p = 0; p < phases; p++) begin
            set_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                       8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                       (p == phases - 1) ? 8'hFF : 8'($urandom_range(1, 4)));
            start = items_sent;
            while (items_sent - start < items_per_phase) begin
                pace_gaps  = ($urandom_range(0, 3) != 0);
                drain_gaps = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
                end else begin
                    key_run(1'b0, $urandom_range(1, cfg_debounce + 4));
                    key_run(1'b1,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(1, cfg_debounce + 4));
                end
            end
            settle();
        end
    endtask

    // The result side holds off for a long stretch while ticks keep coming.
    task automatic test_output_stall();
        set_config(8'd2, 8'd1, 8'd3, 8'd2, 8'd2);
        pace_gaps = 1'b0;
        hold_len  = HOLD_OFF_CYCLES;
        repeat (5) begin
            key_run(1'b0, 4);
            key_run(1'b1, 4);
        end
        settle();
    endtask

    // Result acceptance with random stalls and an occasional long hold-off.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            stall = drain_gaps ? $urandom_range(0, ITEM_GAP_MAX) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each result with the oldest prediction.
    always @(posedge aclk) begin
        hmc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (lamp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN)
                    $display("Unexpected result item %h", m_tdata);
            end else begin
                want = lamp_expected.pop_front();
                if (m_tdata[0] !== want.led_top || m_tdata[1] !== want.front_led ||
                    m_tdata[2] !== want.save_strobe || m_tdata[4:3] !== want.saved_mode ||
                    m_tdata[5] !== want.sleep_request) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOWN)
                        $display({"Result %0d: expected top=%b front=%b save=%b mode=%0d ",
                                  "sleep=%b, got top=%b front=%b save=%b mode=%0d sleep=%b"},
                                 results_seen, want.led_top, want.front_led, want.save_strobe,
                                 want.saved_mode, want.sleep_request, m_tdata[0], m_tdata[1],
                                 m_tdata[2], m_tdata[4:3], m_tdata[5]);
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", lamp_expected.size());
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, then run the tests in turn and report.
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 5'd0;
        pwdata   <= 32'd0;
        lamp_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_directed_modes();
        test_saturated_limits();
        test_output_stall();
        test_press_sequences(4, 35);

        $display("Covered %0d key ticks and %0d results, with %0d mode saves and %0d sleeps",
                 items_sent, results_seen, saves_seen, sleeps_seen);
        $display("Limits ran from 1 to 255, with random stalls and one long output hold-off");
        if (mismatches == 0 && lamp_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, lamp_expected.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/hmc_pkg.sv
rtl/hmc_step.sv
rtl/headlamp_mode_controller.sv
verif/headlamp_mode_controller_test.sv
